[hdl/colour_space_to_rgb_converter_defines.svh]
// Assertion macros used by the colour space converter RTL.
`ifndef COLOUR_SPACE_TO_RGB_CONVERTER_DEFINES_SVH
`define COLOUR_SPACE_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CSRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CSRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/csrgb_pkg.sv]
// Package with types, fixed-point constants and tables of the colour space converter.
`timescale 1ns / 1ps

package csrgb_pkg;

  // Fixed-point format: signed values with FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 16;
  localparam longint Q_ONE = longint'(1) << FRAC_BITS;

  // Widths of the datapath.
  localparam int COMP_W = 8;
  localparam int Q_W    = FRAC_BITS + 1;       // unsigned unit values 0..1
  localparam int MUL_W  = 2 * Q_W;             // product of two unit values
  localparam int COEF_W = FRAC_BITS + 3;       // matrix coefficients, |k| < 4
  localparam int PROD_W = COEF_W + COMP_W + 1; // coefficient times component
  localparam int SUM_W  = PROD_W + 2;          // three products plus offset

  // HSV constants: percent scale and hue steps in halved degrees.
  localparam int PCT_FULL  = 100;
  localparam int PCT_IDX_W = 7;
  localparam int HUE_STEP  = 30;
  localparam int HUE_PAIR  = 2 * HUE_STEP;
  localparam int HUE_MAX_SECTOR = 255 / HUE_STEP;
  localparam int SECTOR_W = 4;
  localparam int HUE_REM_W = 6;
  localparam int CHAN_MAX = 255;

  // Rounding of decimal constants to the fixed-point grid.
  localparam longint MICRO_DEN  = 1000000;
  localparam longint MICRO_HALF = 500000;
  localparam longint MILLI_DEN  = 1000;
  localparam longint MILLI_HALF = 500;

  typedef enum logic [1:0] {
    SPACE_RGB,
    SPACE_HSV,
    SPACE_YCC_FULL,
    SPACE_YCC_BT601
  } space_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  offs_t;
  typedef logic [Q_W-1:0] pct_tbl_t [0:PCT_FULL];
  typedef logic [Q_W-1:0] hue_tbl_t [0:HUE_PAIR-1];

  function automatic longint q_micro(input longint k);
    return ((k << FRAC_BITS) + MICRO_HALF) / MICRO_DEN;
  endfunction

  function automatic longint q_milli(input longint k);
    return ((k << FRAC_BITS) + MILLI_HALF) / MILLI_DEN;
  endfunction

  // Full-range YCbCr coefficients.
  localparam longint K_JR  = q_micro(1402000);
  localparam longint K_JGB = q_micro(344136);
  localparam longint K_JGR = q_micro(714136);
  localparam longint K_JB  = q_micro(1772000);

  // Studio-range BT.601 coefficients and offsets.
  localparam longint K_BY  = q_micro(1164383);
  localparam longint K_BR  = q_micro(1596027);
  localparam longint K_BGB = q_micro(391762);
  localparam longint K_BGR = q_micro(812968);
  localparam longint K_BB  = q_micro(2017232);
  localparam longint K_BOR = q_milli(222921);
  localparam longint K_BOG = q_milli(135576);
  localparam longint K_BOB = q_milli(276836);

  // Matrix per source space: [space][output channel][input component].
  // The HSV row is unused and zero.
  localparam coef_t COEF [4][3][3] = '{
    '{'{coef_t'(Q_ONE), coef_t'(0), coef_t'(0)},
      '{coef_t'(0), coef_t'(Q_ONE), coef_t'(0)},
      '{coef_t'(0), coef_t'(0), coef_t'(Q_ONE)}},
    '{'{coef_t'(0), coef_t'(0), coef_t'(0)},
      '{coef_t'(0), coef_t'(0), coef_t'(0)},
      '{coef_t'(0), coef_t'(0), coef_t'(0)}},
    '{'{coef_t'(Q_ONE), coef_t'(0), coef_t'(K_JR)},
      '{coef_t'(Q_ONE), coef_t'(-K_JGB), coef_t'(-K_JGR)},
      '{coef_t'(Q_ONE), coef_t'(K_JB), coef_t'(0)}},
    '{'{coef_t'(K_BY), coef_t'(0), coef_t'(K_BR)},
      '{coef_t'(K_BY), coef_t'(-K_BGB), coef_t'(-K_BGR)},
      '{coef_t'(K_BY), coef_t'(K_BB), coef_t'(0)}}
  };

  // Constant term per space and channel; the full-range chroma bias of 128
  // is folded in here.
  localparam offs_t OFFS [4][3] = '{
    '{offs_t'(0), offs_t'(0), offs_t'(0)},
    '{offs_t'(0), offs_t'(0), offs_t'(0)},
    '{offs_t'(-128 * K_JR), offs_t'(128 * (K_JGB + K_JGR)), offs_t'(-128 * K_JB)},
    '{offs_t'(-K_BOR), offs_t'(K_BOG), offs_t'(-K_BOB)}
  };

  // Percent to unit fraction, truncated.
  function automatic pct_tbl_t build_pct_tbl();
    pct_tbl_t t;
    for (int i = 0; i <= PCT_FULL; i++) begin
      t[i] = Q_W'((longint'(i) << FRAC_BITS) / PCT_FULL);
    end
    return t;
  endfunction

  // Weight of X relative to C for the hue remainder within a sector pair:
  // 1 - |hue/60 mod 2 - 1|.
  function automatic hue_tbl_t build_hue_tbl();
    hue_tbl_t t;
    longint f;
    longint d;
    for (int i = 0; i < HUE_PAIR; i++) begin
      f = (longint'(i) << FRAC_BITS) / HUE_STEP;
      d = (f >= Q_ONE) ? (f - Q_ONE) : (Q_ONE - f);
      t[i] = Q_W'(Q_ONE - d);
    end
    return t;
  endfunction

  localparam pct_tbl_t PCT_Q = build_pct_tbl();
  localparam hue_tbl_t HUE_W = build_hue_tbl();

endpackage

[hdl/colour_space_to_rgb_converter.sv]
// Top level of the colour space to RGB converter: five-stage pixel pipeline.
`timescale 1ns / 1ps
`include "colour_space_to_rgb_converter_defines.svh"

// Converts one pixel per beat from RGB, HSV, full-range YCbCr or BT.601
// YCbCr to RGB. The source space is set through cfg_wr_en / cfg_wr_data
// and should only change while no pixel is in flight; each beat takes the
// space that is set when it is accepted.
// Input beats arrive on s_axis_* and results leave on m_axis_*, one result
// per input beat, in order. Alpha is copied through unchanged.
// The datapath has five register stages (table lookup and coefficient
// products, chroma and matrix sum, X and m, channel scaling, clamp), the
// last one being the output register; an accepted beat passes through
// the stages in that order to m_axis_*.
// Throughput is one pixel per clock while the receiver takes beats.
// When the receiver stalls, each stage holds its beat; empty stages still
// fill, so up to five beats are held, and s_axis_tready drops only when
// every stage is occupied and the output waits.
// Reset clears all stage valid bits and sets the source space to RGB.
module colour_space_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // first_component, second_component,
                                     // third_component, alpha_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // red, green, blue, alpha_out
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  localparam int STAGES = 5;

  csrgb_pkg::space_t space;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  // Stage 1 combinational inputs.
  logic [csrgb_pkg::COMP_W-1:0]    in_comp [3];
  logic [csrgb_pkg::PCT_IDX_W-1:0] sat_idx;
  logic [csrgb_pkg::PCT_IDX_W-1:0] val_idx;
  logic [csrgb_pkg::SECTOR_W-1:0]  in_sector;
  logic [csrgb_pkg::COMP_W-1:0]    pair_base;
  logic [csrgb_pkg::HUE_REM_W-1:0] hue_rem;
  logic signed [csrgb_pkg::PROD_W-1:0] in_prod [3][3];

  // Stage 1 registers.
  csrgb_pkg::space_t s1_sp;
  logic [7:0] s1_alpha;
  logic [csrgb_pkg::Q_W-1:0] s1_s_q;
  logic [csrgb_pkg::Q_W-1:0] s1_v_q;
  logic [csrgb_pkg::Q_W-1:0] s1_w_q;
  logic [csrgb_pkg::SECTOR_W-1:0] s1_sector;
  logic signed [csrgb_pkg::PROD_W-1:0] s1_prod [3][3];

  // Stage 2 registers.
  csrgb_pkg::space_t s2_sp;
  logic [7:0] s2_alpha;
  logic [csrgb_pkg::Q_W-1:0] s2_c_q;
  logic [csrgb_pkg::Q_W-1:0] s2_v_q;
  logic [csrgb_pkg::Q_W-1:0] s2_w_q;
  logic [csrgb_pkg::SECTOR_W-1:0] s2_sector;
  logic signed [csrgb_pkg::SUM_W-1:0] s2_sum [3];
  logic [csrgb_pkg::MUL_W-1:0] c_full;

  // Stage 3 registers.
  csrgb_pkg::space_t s3_sp;
  logic [7:0] s3_alpha;
  logic [csrgb_pkg::Q_W-1:0] s3_c_q;
  logic [csrgb_pkg::Q_W-1:0] s3_x_q;
  logic [csrgb_pkg::Q_W-1:0] s3_m_q;
  logic [csrgb_pkg::SECTOR_W-1:0] s3_sector;
  logic signed [csrgb_pkg::SUM_W-1:0] s3_sum [3];
  logic [csrgb_pkg::MUL_W-1:0] x_full;

  // Stage 4 registers.
  logic [7:0] s4_alpha;
  logic signed [csrgb_pkg::SUM_W-1:0] s4_val [3];
  logic [csrgb_pkg::Q_W-1:0] hsv_ch [3];
  logic [csrgb_pkg::SUM_W-1:0] hsv_val [3];

  // Output stage.
  logic [7:0] out_chan [3];
  logic [7:0] out_alpha;
  logic [7:0] clamp_chan [3];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      space <= csrgb_pkg::SPACE_RGB;
    end else if (cfg_wr_en) begin
      space <= csrgb_pkg::space_t'(cfg_wr_data);
    end
  end

  // Per-stage advance: a stage loads when it is empty or its successor loads.
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1 logic: percent and hue tables, sector, matrix products.
  always_comb begin
    in_comp[0] = s_axis_tdata[7:0];
    in_comp[1] = s_axis_tdata[15:8];
    in_comp[2] = s_axis_tdata[23:16];

    sat_idx = (in_comp[1] > 8'(csrgb_pkg::PCT_FULL)) ?
              csrgb_pkg::PCT_IDX_W'(csrgb_pkg::PCT_FULL) : in_comp[1][6:0];
    val_idx = (in_comp[2] > 8'(csrgb_pkg::PCT_FULL)) ?
              csrgb_pkg::PCT_IDX_W'(csrgb_pkg::PCT_FULL) : in_comp[2][6:0];

    // Sector is hue / 30, counted against the sector boundaries.
    in_sector = '0;
    for (int k = 1; k <= csrgb_pkg::HUE_MAX_SECTOR; k++) begin
      in_sector = in_sector +
                  csrgb_pkg::SECTOR_W'(in_comp[0] >= 8'(k * csrgb_pkg::HUE_STEP));
    end
    pair_base = 8'({5'b0, in_sector[3:1]}) * 8'(csrgb_pkg::HUE_PAIR);
    hue_rem   = csrgb_pkg::HUE_REM_W'(in_comp[0] - pair_base);

    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        in_prod[c][k] = csrgb_pkg::PROD_W'(csrgb_pkg::COEF[space][c][k]) *
                        $signed(csrgb_pkg::PROD_W'({1'b0, in_comp[k]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_sp     <= space;
      s1_alpha  <= s_axis_tdata[31:24];
      s1_s_q    <= csrgb_pkg::PCT_Q[sat_idx];
      s1_v_q    <= csrgb_pkg::PCT_Q[val_idx];
      s1_w_q    <= csrgb_pkg::HUE_W[hue_rem];
      s1_sector <= in_sector;
      s1_prod   <= in_prod;
    end
  end

  // Stage 2: chroma C = V * S and the matrix sums.
  assign c_full = csrgb_pkg::MUL_W'(s1_v_q) * csrgb_pkg::MUL_W'(s1_s_q);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_sp     <= s1_sp;
      s2_alpha  <= s1_alpha;
      s2_c_q    <= c_full[csrgb_pkg::FRAC_BITS +: csrgb_pkg::Q_W];
      s2_v_q    <= s1_v_q;
      s2_w_q    <= s1_w_q;
      s2_sector <= s1_sector;
      for (int c = 0; c < 3; c++) begin
        s2_sum[c] <= csrgb_pkg::SUM_W'(s1_prod[c][0]) +
                     csrgb_pkg::SUM_W'(s1_prod[c][1]) +
                     csrgb_pkg::SUM_W'(s1_prod[c][2]) +
                     csrgb_pkg::OFFS[s1_sp][c];
      end
    end
  end

  // Stage 3: secondary component X and offset m.
  assign x_full = csrgb_pkg::MUL_W'(s2_c_q) * csrgb_pkg::MUL_W'(s2_w_q);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_sp     <= s2_sp;
      s3_alpha  <= s2_alpha;
      s3_c_q    <= s2_c_q;
      s3_x_q    <= x_full[csrgb_pkg::FRAC_BITS +: csrgb_pkg::Q_W];
      s3_m_q    <= s2_v_q - s2_c_q;
      s3_sector <= s2_sector;
      s3_sum    <= s2_sum;
    end
  end

  // Stage 4: sector selection, scaling to 0..255 in fixed point, and choice of HSV or matrix result.
  always_comb begin
    hsv_ch[0] = s3_m_q;
    hsv_ch[1] = s3_m_q;
    hsv_ch[2] = s3_m_q;
    case (s3_sector)
      4'd0: begin
        hsv_ch[0] = s3_m_q + s3_c_q;
        hsv_ch[1] = s3_m_q + s3_x_q;
      end
      4'd1: begin
        hsv_ch[0] = s3_m_q + s3_x_q;
        hsv_ch[1] = s3_m_q + s3_c_q;
      end
      4'd2: begin
        hsv_ch[1] = s3_m_q + s3_c_q;
        hsv_ch[2] = s3_m_q + s3_x_q;
      end
      4'd3: begin
        hsv_ch[1] = s3_m_q + s3_x_q;
        hsv_ch[2] = s3_m_q + s3_c_q;
      end
      4'd4: begin
        hsv_ch[0] = s3_m_q + s3_x_q;
        hsv_ch[2] = s3_m_q + s3_c_q;
      end
      4'd5: begin
        hsv_ch[0] = s3_m_q + s3_c_q;
        hsv_ch[2] = s3_m_q + s3_x_q;
      end
      default: begin
        // Hue beyond the last sector: gray at level m.
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      hsv_val[c] = csrgb_pkg::SUM_W'(hsv_ch[c]) * csrgb_pkg::SUM_W'(csrgb_pkg::CHAN_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_alpha <= s3_alpha;
      for (int c = 0; c < 3; c++) begin
        s4_val[c] <= (s3_sp == csrgb_pkg::SPACE_HSV) ? $signed(hsv_val[c]) : s3_sum[c];
      end
    end
  end

  // Stage 5: truncate to integer and clamp to 0..255.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s4_val[c][csrgb_pkg::SUM_W-1]) begin
        clamp_chan[c] = '0;
      end else if (s4_val[c][csrgb_pkg::SUM_W-2:csrgb_pkg::FRAC_BITS] >
                   (csrgb_pkg::SUM_W-1-csrgb_pkg::FRAC_BITS)'(csrgb_pkg::CHAN_MAX)) begin
        clamp_chan[c] = 8'(csrgb_pkg::CHAN_MAX);
      end else begin
        clamp_chan[c] = s4_val[c][csrgb_pkg::FRAC_BITS +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_chan  <= clamp_chan;
      out_alpha <= s4_alpha;
    end
  end

  assign m_axis_tvalid = vld[STAGES-1];
  assign m_axis_tdata  = {out_alpha, out_chan[2], out_chan[1], out_chan[0]};

  // Input is refused only when every stage holds a beat.
  `CSRGB_ASSERT_NOW(a_ready_only_when_full, !s_axis_tready, &vld, "input stalled with an empty stage")
  // Chroma never exceeds value.
  `CSRGB_ASSERT_NOW(a_chroma_le_value, vld[1] && s2_sp == csrgb_pkg::SPACE_HSV, s2_c_q <= s2_v_q, "chroma above value")
  // X never exceeds chroma.
  `CSRGB_ASSERT_NOW(a_x_le_chroma, vld[2] && s3_sp == csrgb_pkg::SPACE_HSV, s3_x_q <= s3_c_q, "X above chroma")
  // A beat moved out of stage four shows up at the output.
  `CSRGB_ASSERT_NEXT(a_stage4_to_out, vld[3] && adv[4], m_axis_tvalid, "beat lost before output")

endmodule

[sim/tb_colour_space_to_rgb_converter.sv]
// Self-checking testbench for the colour space to RGB converter.
`timescale 1ns / 1ps

module tb_colour_space_to_rgb_converter;
  import csrgb_pkg::*;

  // Fixed-point format of the predictor and decimal scales of its constants.
  localparam int     FRAC        = 16;
  localparam longint MICRO       = 1000000;
  localparam longint MILLI       = 1000;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     RAND_PHASES = 14;
  localparam int     PHASE_ITEMS = 100;

  // Input beat, first_component in the lowest byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] third;
    logic [7:0] second;
    logic [7:0] first;
  } pixel_in_t;

  // Result beat, red in the lowest byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  // Holds the source space and the expected results of accepted beats.
  class rgb_scoreboard;
    space_t space;
    rgba_t  expected_rgba[$];
    int     errors;

    function new();
      space  = SPACE_RGB;
      errors = 0;
    endfunction

    // Decimal constant scaled by den, converted to fixed point with rounding.
    static function longint to_q(longint k, longint den);
      return ((k << FRAC) + den / 2) / den;
    endfunction

    // Truncates a fixed-point channel to an integer and clamps it to a byte.
    static function logic [7:0] clamp_channel(longint acc);
      longint w;
      if (acc < 0) return 8'd0;
      w = acc >>> FRAC;
      if (w > 255) return 8'd255;
      return w[7:0];
    endfunction

    // Scales a unit channel in 0..1 to 0..255.
    static function logic [7:0] unit_to_byte(longint u);
      if (u < 0) return 8'd0;
      return clamp_channel(u * 255);
    endfunction

    static function rgba_t hsv_to_rgb(pixel_in_t p);
      rgba_t  o;
      longint h, s, v, q_one, s_q, v_q, c_q, f_q, d, x_q, m_q;
      longint ch_r, ch_g, ch_b;
      h = p.first;
      s = (p.second > 100) ? 100 : p.second;
      v = (p.third > 100) ? 100 : p.third;
      q_one = longint'(1) << FRAC;
      s_q = (s << FRAC) / 100;
      v_q = (v << FRAC) / 100;
      c_q = (v_q * s_q) >>> FRAC;
      f_q = ((h % 60) << FRAC) / 30;
      d = f_q - q_one;
      if (d < 0) d = -d;
      x_q = (c_q * (q_one - d)) >>> FRAC;
      m_q = v_q - c_q;
      ch_r = m_q;
      ch_g = m_q;
      ch_b = m_q;
      // Hue sectors of 60 degrees; beyond the sixth all channels stay at m.
      case (h / 30)
        0: begin ch_r += c_q; ch_g += x_q; end
        1: begin ch_r += x_q; ch_g += c_q; end
        2: begin ch_g += c_q; ch_b += x_q; end
        3: begin ch_g += x_q; ch_b += c_q; end
        4: begin ch_r += x_q; ch_b += c_q; end
        5: begin ch_r += c_q; ch_b += x_q; end
        default: ;
      endcase
      o.red   = unit_to_byte(ch_r);
      o.green = unit_to_byte(ch_g);
      o.blue  = unit_to_byte(ch_b);
      o.alpha = p.alpha;
      return o;
    endfunction

    static function rgba_t ycc_full_to_rgb(pixel_in_t p);
      rgba_t  o;
      longint yq, cb, cr;
      yq = longint'(p.first) << FRAC;
      cb = longint'(p.second) - 128;
      cr = longint'(p.third) - 128;
      o.red   = clamp_channel(yq + to_q(1402000, MICRO) * cr);
      o.green = clamp_channel(yq - to_q(344136, MICRO) * cb - to_q(714136, MICRO) * cr);
      o.blue  = clamp_channel(yq + to_q(1772000, MICRO) * cb);
      o.alpha = p.alpha;
      return o;
    endfunction

    static function rgba_t ycc_bt601_to_rgb(pixel_in_t p);
      rgba_t  o;
      longint yq, cb, cr;
      yq = to_q(1164383, MICRO) * longint'(p.first);
      cb = p.second;
      cr = p.third;
      o.red   = clamp_channel(yq + to_q(1596027, MICRO) * cr - to_q(222921, MILLI));
      o.green = clamp_channel(yq - to_q(391762, MICRO) * cb - to_q(812968, MICRO) * cr
                              + to_q(135576, MILLI));
      o.blue  = clamp_channel(yq + to_q(2017232, MICRO) * cb - to_q(276836, MILLI));
      o.alpha = p.alpha;
      return o;
    endfunction

    function rgba_t convert_to_rgba(pixel_in_t p);
      rgba_t o;
      case (space)
        SPACE_HSV:       o = hsv_to_rgb(p);
        SPACE_YCC_FULL:  o = ycc_full_to_rgb(p);
        SPACE_YCC_BT601: o = ycc_bt601_to_rgb(p);
        default:         o = {p.alpha, p.third, p.second, p.first};
      endcase
      return o;
    endfunction

    function void note_pixel(pixel_in_t p);
      expected_rgba.push_back(convert_to_rgba(p));
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (expected_rgba.size() == 0) begin
        $error("result beat 0x%08h with no pixel outstanding", got);
        errors++;
        return;
      end
      want = expected_rgba.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha_out", want.alpha, got.alpha);
    endfunction

    function int pending();
      return expected_rgba.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // first_component, second_component, third_component, alpha_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // red, green, blue, alpha_out
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;

  rgb_scoreboard sb;
  bit            steady;
  int            hold_left;
  int            cycle_count;

  colour_space_to_rgb_converter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Idle length in cycles: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic pixel_in_t pix(int f, int s, int t, int a);
    return {a[7:0], t[7:0], s[7:0], f[7:0]};
  endfunction

  // Well-formed HSV beats most of the time, any byte values otherwise.
  function automatic pixel_in_t random_pixel(space_t sp);
    pixel_in_t p;
    p = $urandom;
    if (sp == SPACE_HSV && $urandom_range(0, 99) < 85) begin
      p.first  = $urandom_range(0, 179);
      p.second = $urandom_range(0, 100);
      p.third  = $urandom_range(0, 100);
    end
    return p;
  endfunction

  // Receiver: random stalls of varying length, none while steady.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: notes each accepted input beat and checks each result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("colour_space_to_rgb_converter regression: fail");
      $finish;
    end
  end

  // Writes the source space; called only with the pipeline empty.
  task automatic write_space(space_t sp);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sp;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.space = sp;
  endtask

  // Presents one beat, at times after a random gap, and waits for its acceptance.
  task automatic send_pixel(pixel_in_t p);
    int gap;
    gap = (steady || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    space_t sp;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    steady = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Passthrough: all zeros, all ones and a mixed pattern.
    write_space(SPACE_RGB);
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(255, 255, 255, 255));
    send_pixel(pix(8'h3c, 8'hc3, 8'h5a, 8'ha5));
    drain_results();

    // HSV: sector edges, hue past the last sector, saturation and value
    // above 100 percent, and a grey pixel.
    write_space(SPACE_HSV);
    send_pixel(pix(0, 100, 100, 255));
    send_pixel(pix(29, 100, 100, 0));
    send_pixel(pix(30, 80, 60, 17));
    send_pixel(pix(59, 100, 100, 128));
    send_pixel(pix(90, 50, 100, 1));
    send_pixel(pix(150, 100, 75, 254));
    send_pixel(pix(179, 100, 100, 64));
    send_pixel(pix(180, 100, 100, 200));
    send_pixel(pix(255, 255, 255, 255));
    send_pixel(pix(45, 101, 255, 9));
    send_pixel(pix(120, 0, 100, 33));
    drain_results();

    // Full-range YCbCr: clamping at both ends and the neutral point.
    write_space(SPACE_YCC_FULL);
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(255, 255, 255, 255));
    send_pixel(pix(128, 128, 128, 77));
    send_pixel(pix(0, 255, 0, 12));
    drain_results();

    // BT.601: extremes plus studio black and white.
    write_space(SPACE_YCC_BT601);
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(255, 255, 255, 255));
    send_pixel(pix(16, 128, 128, 90));
    send_pixel(pix(235, 128, 128, 160));
    drain_results();

    // Random phases, each with its own source space and idling style.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sp = (ph < 4) ? space_t'((ph + 1) % 4) : space_t'($urandom_range(0, 3));
      steady = ($urandom_range(0, 3) == 0);
      write_space(sp);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(random_pixel(sp));
      end
      drain_results();
    end

    steady = 1'b0;
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("colour_space_to_rgb_converter regression: pass");
    end else begin
      $display("colour_space_to_rgb_converter regression: fail");
    end
    $finish;
  end

endmodule
